@@ rtl/core/i2cbm_pkg.sv @@
// Package for the I2C bit-level master: phase, command and register codes, timing constants.
`default_nettype none

package i2cbm_pkg;

  // Sequencer phases: idle, one per pin action or SCL check of a bus sequence, and finish
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST0      = 5'd1,
    PH_ST1      = 5'd2,
    PH_ST2      = 5'd3,
    PH_ST3      = 5'd4,
    PH_SP0      = 5'd5,
    PH_SP1      = 5'd6,
    PH_SP2      = 5'd7,
    PH_SP3      = 5'd8,
    PH_WDATA    = 5'd9,
    PH_WHIGH    = 5'd10,
    PH_WLOW     = 5'd11,
    PH_WACKCLK  = 5'd12,
    PH_WACKSMP  = 5'd13,
    PH_RCLKHI   = 5'd14,
    PH_RSTRETCH = 5'd15,
    PH_RPOLL    = 5'd16,
    PH_RSAMPLE  = 5'd17,
    PH_RACKDRV  = 5'd18,
    PH_RACKHI   = 5'd19,
    PH_RACKLO   = 5'd20,
    PH_FIN      = 5'd21
  } phase_e;

  // Command codes carried in the request kind
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Register indexes (byte address is 4x the index)
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_STRETCH_LIM  = 2'd1;
  localparam logic [1:0] REG_BYTE_GAP     = 2'd2;

  // Register reset values
  localparam logic [9:0] TICKS_PER_US_RST = 10'd100;
  localparam logic [7:0] STRETCH_LIM_RST  = 8'd250;
  localparam logic [7:0] BYTE_GAP_RST     = 8'd20;

  // Delays in microseconds
  localparam int unsigned STRETCH_POLL_US_DEF = 1000;
  localparam logic [9:0]  EDGE_US   = 10'd1;
  localparam logic [9:0]  HOLD_US   = 10'd10;
  localparam logic [9:0]  HIGH_US   = 10'd5;
  localparam logic [9:0]  SAMPLE_US = 10'd3;

  // Bits in a byte on the wire
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

@@ rtl/core/i2c_bit_level_master.sv @@
// Top level of the I2C bit-level master: stream channels, APB registers and the bus sequencer.
//
// Usage: every request on the slave stream is one bus tick. Its tdata carries the sampled
// SDA/SCL levels and, when cmd_valid is set, a command whose code travels in tuser
// (start/repeated start, stop, write byte, read byte). Every request produces exactly one
// result on the master stream: the SCL/SDA release levels to drive onto the open-drain
// pins, busy/done status, the write ACK, the last read byte and the stretch-timeout flag.
// Commands offered while a sequence runs are ignored.
// Path: a request is held in the input register, then its result in the output register.
// Throughput: one request per cycle while the receiver keeps taking results; the sequencer
// updates all its state in a single pass.
// The output register is the only buffer between the sides: while it holds a result that
// is not taken, the input register may still fill, after which tready drops until the
// receiver takes the result. Bus timing counts requests, not clock cycles.
// Reset: both lines released, sequencer idle, flags and read byte cleared, registers at
// 100 ticks per microsecond, 250 stretch polls and a 20 us byte gap. The user must write
// registers over APB only while the block is idle; the block itself does not enforce it.
`default_nettype none

module i2c_bit_level_master #(
  parameter int unsigned STRETCH_POLL_US = i2cbm_pkg::STRETCH_POLL_US_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_in, [11] scl_in, [15:12] zero
  input  wire logic [15:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res, [4] ack_ok,
  // [12:5] rx_byte, [13] stretch_timeout, [15:14] zero
  output logic [15:0]      m_axis_tdata,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [9:0] PollUs = 10'(STRETCH_POLL_US);

  // Configuration registers
  logic [9:0] tpu_q;
  logic [7:0] slim_q;
  logic [7:0] gap_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q  <= i2cbm_pkg::TICKS_PER_US_RST;
      slim_q <= i2cbm_pkg::STRETCH_LIM_RST;
      gap_q  <= i2cbm_pkg::BYTE_GAP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        i2cbm_pkg::REG_TICKS_PER_US: tpu_q  <= pwdata[9:0];
        i2cbm_pkg::REG_STRETCH_LIM:  slim_q <= pwdata[7:0];
        i2cbm_pkg::REG_BYTE_GAP:     gap_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      i2cbm_pkg::REG_TICKS_PER_US: prdata = {22'd0, tpu_q};
      i2cbm_pkg::REG_STRETCH_LIM:  prdata = {24'd0, slim_q};
      i2cbm_pkg::REG_BYTE_GAP:     prdata = {24'd0, gap_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // Input register and output register handshake
  logic        in_v_q;
  logic [15:0] in_data_q;
  logic [1:0]  in_op_q;
  logic        out_v_q;
  logic [15:0] out_data_q;
  logic        advance;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_op_q   <= s_axis_tuser;
    end
  end

  // Unpacked fields of the registered request
  logic       cmd_valid;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;
  logic       scl_in;
  i2cbm_pkg::op_e op;

  assign cmd_valid = in_data_q[0];
  assign tx_byte   = in_data_q[8:1];
  assign send_ack  = in_data_q[9];
  assign sda_in    = in_data_q[10];
  assign scl_in    = in_data_q[11];
  assign op        = i2cbm_pkg::op_e'(in_op_q);

  // Sequencer state
  i2cbm_pkg::phase_e phase_q, phase_d, cur_ph;
  logic [3:0] bitc_q, bitc_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] rx_q, rx_d;
  logic [9:0] pre_q, pre_d;
  logic [9:0] us_q, us_d;
  logic [7:0] stc_q, stc_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       lack_q, lack_d;
  logic       ack_q, ack_d;
  logic       tmo_q, tmo_d;
  logic       done_d;
  logic       act;
  logic [9:0] wait_us;
  logic [9:0] tpu_eff;

  assign tpu_eff = (tpu_q == 10'd0) ? 10'd1 : tpu_q;

  // One bus tick: command accept or timer count, then at most one pin action
  // plus the completion step when the byte gap is zero
  always_comb begin
    phase_d = phase_q;
    bitc_d  = bitc_q;
    shift_d = shift_q;
    rx_d    = rx_q;
    pre_d   = pre_q;
    us_d    = us_q;
    stc_d   = stc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    lack_d  = lack_q;
    ack_d   = ack_q;
    tmo_d   = tmo_q;
    done_d  = 1'b0;
    act     = 1'b0;
    wait_us = 10'd0;

    if (phase_q == i2cbm_pkg::PH_IDLE) begin
      if (cmd_valid) begin
        lack_d = send_ack;
        bitc_d = 4'd0;
        act    = 1'b1;
        case (op)
          i2cbm_pkg::OP_START: phase_d = i2cbm_pkg::PH_ST0;
          i2cbm_pkg::OP_STOP:  phase_d = i2cbm_pkg::PH_SP0;
          i2cbm_pkg::OP_WRITE: begin
            shift_d = tx_byte;
            ack_d   = 1'b0;
            phase_d = i2cbm_pkg::PH_WDATA;
          end
          default: begin
            shift_d = 8'd0;
            tmo_d   = 1'b0;
            sda_d   = 1'b1;
            phase_d = i2cbm_pkg::PH_RCLKHI;
          end
        endcase
      end
    end else begin
      pre_d = pre_q + 10'd1;
      if (pre_d >= tpu_eff) begin
        pre_d = 10'd0;
        if (us_d != 10'd0) us_d = us_d - 10'd1;
      end
      if (us_d == 10'd0) act = 1'b1;
    end

    cur_ph = phase_d;
    if (act) begin
      case (cur_ph)
        i2cbm_pkg::PH_ST0: begin sda_d = 1'b1; phase_d = i2cbm_pkg::PH_ST1; wait_us = i2cbm_pkg::EDGE_US; end
        i2cbm_pkg::PH_ST1: begin scl_d = 1'b1; phase_d = i2cbm_pkg::PH_ST2; wait_us = i2cbm_pkg::EDGE_US; end
        i2cbm_pkg::PH_ST2: begin sda_d = 1'b0; phase_d = i2cbm_pkg::PH_ST3; wait_us = i2cbm_pkg::HOLD_US; end
        i2cbm_pkg::PH_ST3: begin scl_d = 1'b0; phase_d = i2cbm_pkg::PH_FIN; wait_us = i2cbm_pkg::HOLD_US; end
        i2cbm_pkg::PH_SP0: begin scl_d = 1'b0; phase_d = i2cbm_pkg::PH_SP1; wait_us = i2cbm_pkg::EDGE_US; end
        i2cbm_pkg::PH_SP1: begin sda_d = 1'b0; phase_d = i2cbm_pkg::PH_SP2; wait_us = i2cbm_pkg::EDGE_US; end
        i2cbm_pkg::PH_SP2: begin scl_d = 1'b1; phase_d = i2cbm_pkg::PH_SP3; wait_us = i2cbm_pkg::HOLD_US; end
        i2cbm_pkg::PH_SP3: begin sda_d = 1'b1; phase_d = i2cbm_pkg::PH_FIN; wait_us = i2cbm_pkg::HOLD_US; end
        i2cbm_pkg::PH_WDATA: begin
          sda_d   = shift_d[7];
          phase_d = i2cbm_pkg::PH_WHIGH;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_WHIGH: begin
          scl_d   = 1'b1;
          phase_d = i2cbm_pkg::PH_WLOW;
          wait_us = i2cbm_pkg::HIGH_US;
        end
        i2cbm_pkg::PH_WLOW: begin
          scl_d   = 1'b0;
          shift_d = {shift_d[6:0], 1'b0};
          bitc_d  = bitc_d + 4'd1;
          phase_d = (bitc_d < i2cbm_pkg::BITS_PER_BYTE) ? i2cbm_pkg::PH_WDATA
                                                        : i2cbm_pkg::PH_WACKCLK;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_WACKCLK: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          phase_d = i2cbm_pkg::PH_WACKSMP;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_WACKSMP: begin
          ack_d   = !sda_in;
          scl_d   = 1'b0;
          phase_d = i2cbm_pkg::PH_FIN;
          wait_us = {2'd0, gap_q};
        end
        i2cbm_pkg::PH_RCLKHI: begin
          scl_d   = 1'b1;
          phase_d = i2cbm_pkg::PH_RSTRETCH;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_RSTRETCH, i2cbm_pkg::PH_RPOLL: begin
          // clock stretch check: reload the poll budget on the first look
          if (cur_ph == i2cbm_pkg::PH_RSTRETCH) stc_d = slim_q;
          if (scl_in) begin
            phase_d = i2cbm_pkg::PH_RSAMPLE;
            wait_us = i2cbm_pkg::SAMPLE_US;
          end else begin
            stc_d = stc_d - 8'd1;
            if (stc_d == 8'd0) begin
              tmo_d   = 1'b1;
              phase_d = i2cbm_pkg::PH_RSAMPLE;
              wait_us = i2cbm_pkg::SAMPLE_US;
            end else begin
              phase_d = i2cbm_pkg::PH_RPOLL;
              wait_us = PollUs;
            end
          end
        end
        i2cbm_pkg::PH_RSAMPLE: begin
          shift_d = {shift_d[6:0], sda_in};
          scl_d   = 1'b0;
          bitc_d  = bitc_d + 4'd1;
          phase_d = (bitc_d < i2cbm_pkg::BITS_PER_BYTE) ? i2cbm_pkg::PH_RCLKHI
                                                        : i2cbm_pkg::PH_RACKDRV;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_RACKDRV: begin
          sda_d   = !lack_d;
          phase_d = i2cbm_pkg::PH_RACKHI;
          wait_us = i2cbm_pkg::EDGE_US;
        end
        i2cbm_pkg::PH_RACKHI: begin
          scl_d   = 1'b1;
          phase_d = i2cbm_pkg::PH_RACKLO;
          wait_us = i2cbm_pkg::HIGH_US;
        end
        i2cbm_pkg::PH_RACKLO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          rx_d    = shift_d;
          phase_d = i2cbm_pkg::PH_FIN;
          wait_us = {2'd0, gap_q};
        end
        default: begin
          // end of sequence
          phase_d = i2cbm_pkg::PH_IDLE;
          done_d  = 1'b1;
          wait_us = 10'd0;
        end
      endcase
      pre_d = 10'd0;
      us_d  = wait_us;
      // zero byte gap: finish in the same tick
      if (wait_us == 10'd0 && phase_d == i2cbm_pkg::PH_FIN) begin
        phase_d = i2cbm_pkg::PH_IDLE;
        done_d  = 1'b1;
      end
    end
  end

  // Sequencer state update, once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cbm_pkg::PH_IDLE;
      bitc_q  <= 4'd0;
      shift_q <= 8'd0;
      rx_q    <= 8'd0;
      pre_q   <= 10'd0;
      us_q    <= 10'd0;
      stc_q   <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      lack_q  <= 1'b0;
      ack_q   <= 1'b0;
      tmo_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      bitc_q  <= bitc_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      pre_q   <= pre_d;
      us_q    <= us_d;
      stc_q   <= stc_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      lack_q  <= lack_d;
      ack_q   <= ack_d;
      tmo_q   <= tmo_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'd0, tmo_d, rx_d, ack_d, done_d,
                     (phase_d != i2cbm_pkg::PH_IDLE), sda_d, scl_d};
    end
  end

`ifndef ASSERT_OFF
  // A running sequence always has a pending wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != i2cbm_pkg::PH_IDLE |-> us_q != 10'd0)
    else $error("running sequence with no pending wait");

  // The tick prescaler stays below the microsecond length while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != i2cbm_pkg::PH_IDLE |-> pre_q < tpu_eff)
    else $error("prescaler past microsecond length");

  // Bit counter never passes one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitc_q <= i2cbm_pkg::BITS_PER_BYTE)
    else $error("bit counter overflow");

  // A completion result never reports busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_data_q[3] |-> !out_data_q[2])
    else $error("done reported while busy");

  // A sequencer step leaves the previous result either taken or replaced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_v_q)
    else $error("result lost after sequencer step");
`endif

endmodule

`default_nettype wire

@@ tb/tb_i2c_bit_level_master.sv @@
// Testbench for the I2C bit-level master: per-tick bus model, directed and random traffic.
module tb_i2c_bit_level_master;
  import i2cbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One result as it sits in m_axis_tdata, lowest bit last
  typedef struct packed {
    logic [1:0] pad;
    logic       tmo;
    logic [7:0] rx;
    logic       ack;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } bus_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_in, [11] scl_in, [15:12] zero
  logic [15:0] s_axis_tdata;
  // [1:0] op
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res, [4] ack_ok,
  // [12:5] rx_byte, [13] stretch_timeout, [15:14] zero
  logic [15:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_bit_level_master u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Bus engine model state
  phase_e      seq_phase     = PH_IDLE;
  logic [3:0]  seq_bits      = '0;
  logic [7:0]  seq_shift     = '0;
  logic [7:0]  rx_hold       = '0;
  logic [9:0]  tick_div      = '0;
  logic [9:0]  us_left       = '0;
  logic [7:0]  polls_left    = '0;
  logic        scl_drv       = 1'b1;
  logic        sda_drv       = 1'b1;
  logic        ack_to_send   = 1'b0;
  logic        slave_acked   = 1'b0;
  logic        stretch_tmo   = 1'b0;
  logic        done_now      = 1'b0;
  int unsigned scl_low_polls = 0;

  // Register copies
  logic [9:0]  ticks_per_us = TICKS_PER_US_RST;
  logic [7:0]  poll_limit   = STRETCH_LIM_RST;
  logic [7:0]  gap_us       = BYTE_GAP_RST;

  // Stimulus shaping
  bus_result_t expected_results[$];
  int          sda_force      = -1;  // -1 random, else the forced SDA level
  int unsigned scl_low_budget = 0;   // stretch checks still to answer with SCL low
  bit          src_idle_en    = 1'b0;
  bit          sink_idle_en   = 1'b0;
  bit          noise_en       = 1'b0;
  int unsigned sink_hold      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic op_e any_op();
    return op_e'($urandom_range(0, 3));
  endfunction

  // One SCL check during a read bit; returns the wait in microseconds
  function automatic int stretch_poll(logic scl);
    if (scl) begin
      seq_phase = PH_RSAMPLE;
      return SAMPLE_US;
    end
    scl_low_polls++;
    polls_left = polls_left - 8'd1;
    if (polls_left == 8'd0) begin
      stretch_tmo = 1'b1;
      seq_phase   = PH_RSAMPLE;
      return SAMPLE_US;
    end
    seq_phase = PH_RPOLL;
    return STRETCH_POLL_US_DEF;
  endfunction

  // Pin action of the current phase; returns the wait that follows
  function automatic int pin_action(logic sda, logic scl);
    case (seq_phase)
      PH_ST0: begin sda_drv = 1'b1; seq_phase = PH_ST1; return EDGE_US; end
      PH_ST1: begin scl_drv = 1'b1; seq_phase = PH_ST2; return EDGE_US; end
      PH_ST2: begin sda_drv = 1'b0; seq_phase = PH_ST3; return HOLD_US; end
      PH_ST3: begin scl_drv = 1'b0; seq_phase = PH_FIN; return HOLD_US; end
      PH_SP0: begin scl_drv = 1'b0; seq_phase = PH_SP1; return EDGE_US; end
      PH_SP1: begin sda_drv = 1'b0; seq_phase = PH_SP2; return EDGE_US; end
      PH_SP2: begin scl_drv = 1'b1; seq_phase = PH_SP3; return HOLD_US; end
      PH_SP3: begin sda_drv = 1'b1; seq_phase = PH_FIN; return HOLD_US; end
      PH_WDATA: begin
        sda_drv   = seq_shift[7];
        seq_phase = PH_WHIGH;
        return EDGE_US;
      end
      PH_WHIGH: begin scl_drv = 1'b1; seq_phase = PH_WLOW; return HIGH_US; end
      PH_WLOW: begin
        scl_drv   = 1'b0;
        seq_shift = {seq_shift[6:0], 1'b0};
        seq_bits  = seq_bits + 4'd1;
        seq_phase = (seq_bits < BITS_PER_BYTE) ? PH_WDATA : PH_WACKCLK;
        return EDGE_US;
      end
      PH_WACKCLK: begin
        sda_drv   = 1'b1;
        scl_drv   = 1'b1;
        seq_phase = PH_WACKSMP;
        return EDGE_US;
      end
      PH_WACKSMP: begin
        slave_acked = ~sda;
        scl_drv     = 1'b0;
        seq_phase   = PH_FIN;
        return gap_us;
      end
      PH_RCLKHI: begin scl_drv = 1'b1; seq_phase = PH_RSTRETCH; return EDGE_US; end
      PH_RSTRETCH: begin
        polls_left = poll_limit;
        return stretch_poll(scl);
      end
      PH_RPOLL: return stretch_poll(scl);
      PH_RSAMPLE: begin
        seq_shift = {seq_shift[6:0], sda};
        scl_drv   = 1'b0;
        seq_bits  = seq_bits + 4'd1;
        seq_phase = (seq_bits < BITS_PER_BYTE) ? PH_RCLKHI : PH_RACKDRV;
        return EDGE_US;
      end
      PH_RACKDRV: begin
        sda_drv   = ~ack_to_send;
        seq_phase = PH_RACKHI;
        return EDGE_US;
      end
      PH_RACKHI: begin scl_drv = 1'b1; seq_phase = PH_RACKLO; return HIGH_US; end
      PH_RACKLO: begin
        scl_drv   = 1'b0;
        sda_drv   = 1'b1;
        rx_hold   = seq_shift;
        seq_phase = PH_FIN;
        return gap_us;
      end
      default: begin
        seq_phase = PH_IDLE;
        done_now  = 1'b1;
        return 0;
      end
    endcase
  endfunction

  // Chain actions until one leaves a nonzero wait or the command ends
  function automatic void run_actions(logic sda, logic scl);
    int d;
    for (int g = 0; g < 8; g++) begin
      if (seq_phase == PH_IDLE) break;
      d        = pin_action(sda, scl);
      tick_div = '0;
      us_left  = d[9:0];
      if (us_left != 0) break;
    end
  endfunction

  // Advance the engine model by one request and return its result
  function automatic bus_result_t bus_model_tick(logic cv, op_e op, logic [7:0] tx,
                                                 logic ack, logic sda, logic scl);
    logic [9:0]  tpu;
    bus_result_t r;
    tpu      = (ticks_per_us == 10'd0) ? 10'd1 : ticks_per_us;
    done_now = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (cv) begin
        ack_to_send = ack;
        seq_bits    = '0;
        case (op)
          OP_START: seq_phase = PH_ST0;
          OP_STOP:  seq_phase = PH_SP0;
          OP_WRITE: begin
            seq_shift   = tx;
            slave_acked = 1'b0;
            seq_phase   = PH_WDATA;
          end
          default: begin
            seq_shift   = '0;
            stretch_tmo = 1'b0;
            sda_drv     = 1'b1;
            seq_phase   = PH_RCLKHI;
          end
        endcase
        run_actions(sda, scl);
      end
    end else begin
      tick_div = tick_div + 10'd1;
      if (tick_div >= tpu) begin
        tick_div = '0;
        if (us_left != 0) us_left = us_left - 10'd1;
      end
      if (us_left == 0) run_actions(sda, scl);
    end
    r      = '0;
    r.scl  = scl_drv;
    r.sda  = sda_drv;
    r.busy = (seq_phase != PH_IDLE);
    r.done = done_now;
    r.ack  = slave_acked;
    r.rx   = rx_hold;
    r.tmo  = stretch_tmo;
    return r;
  endfunction

  // Send one request (one bus tick) and queue its expected result
  task automatic bus_tick(input logic cv, input op_e op, input logic [7:0] tx,
                          input logic ack);
    logic        sda;
    logic        scl;
    int unsigned seen;
    int          gap;
    sda = (sda_force < 0) ? 1'($urandom_range(0, 1)) : sda_force[0];
    if (seq_phase == PH_RSTRETCH || seq_phase == PH_RPOLL) scl = (scl_low_budget == 0);
    else scl = 1'($urandom_range(0, 1));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, scl, sda, ack, tx, cv};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    seen = scl_low_polls;
    expected_results.push_back(bus_model_tick(cv, op, tx, ack, sda, scl));
    if (scl_low_polls != seen && scl_low_budget > 0) scl_low_budget--;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Issue one command and tick until it completes
  task automatic run_cmd(input op_e op, input logic [7:0] tx, input logic ack);
    bus_tick(1'b1, op, tx, ack);
    while (seq_phase != PH_IDLE) begin
      // ignored commands while busy
      bus_tick(noise_en && ($urandom_range(0, 15) == 0), any_op(),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Stop sending and drain all outstanding results
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TICKS_PER_US: ticks_per_us = val[9:0];
      REG_STRETCH_LIM:  poll_limit   = val[7:0];
      default:          gap_us       = val[7:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned tpu, input int unsigned lim,
                            input int unsigned gap);
    settle();
    reg_write(REG_TICKS_PER_US, tpu);
    reg_write(REG_STRETCH_LIM, lim);
    reg_write(REG_BYTE_GAP, gap);
  endtask

  // Outputs straight after reset, then a full transfer with the reset poll limit and gap
  task automatic test_reset_config();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (8) bus_tick(1'b0, OP_START, 8'h00, 1'b0);
    settle();
    reg_write(REG_TICKS_PER_US, 32'd1);
    sda_force    = 0;
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0);
    sda_force = 1;
    run_cmd(OP_READ, 8'h00, 1'b1);
    sda_force = -1;
    run_cmd(OP_STOP, 8'h00, 1'b0);
  endtask

  // Zero ticks per microsecond counts as one
  task automatic test_ticks_zero();
    set_config(0, 250, 20);
    run_cmd(OP_START, 8'h00, 1'b0);
  endtask

  // Every command, data extremes, ACK/NACK, zero and maximum byte gap
  task automatic test_commands();
    set_config(1, 250, 0);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    noise_en     = 1'b1;
    run_cmd(OP_START, 8'h00, 1'b0);
    sda_force = 0;
    run_cmd(OP_WRITE, 8'h00, 1'b0);
    sda_force = 1;
    run_cmd(OP_WRITE, 8'hFF, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b1);
    sda_force = 0;
    run_cmd(OP_READ, 8'hFF, 1'b0);
    sda_force = -1;
    run_cmd(OP_READ, 8'h00, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'h5A, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    set_config(1, 250, 255);
    run_cmd(OP_WRITE, 8'h81, 1'b0);
    noise_en = 1'b0;
  endtask

  // SCL held low by the slave: recovery, timeout, flag hold and clear
  task automatic test_clock_stretch();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config(1, 2, 2);
    run_cmd(OP_START, 8'h00, 1'b0);
    // one poll, then the slave lets go
    scl_low_budget = 1;
    run_cmd(OP_READ, 8'h00, 1'b1);
    // every bit times out on its first check
    set_config(1, 1, 2);
    scl_low_budget = 8;
    run_cmd(OP_READ, 8'h00, 1'b0);
    // timeout flag survives a write and a start
    run_cmd(OP_WRITE, 8'h3C, 1'b0);
    run_cmd(OP_START, 8'h00, 1'b0);
    // next read clears it
    set_config(1, 255, 2);
    run_cmd(OP_READ, 8'h00, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold    = 150;
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
  endtask

  // Random transactions: start, bytes, repeated start or stop, plus stray commands
  task automatic random_traffic(input int unsigned n);
    int unsigned count;
    int unsigned r;
    int unsigned bytes_left;
    bit          in_xfer;
    logic        cv;
    op_e         op;
    count   = 0;
    in_xfer = 1'b0;
    bytes_left = 0;
    // run on until the last command has finished
    while (count < n || seq_phase != PH_IDLE) begin
      if (seq_phase != PH_IDLE) begin
        cv = ($urandom_range(0, 9) == 0);
        bus_tick(cv, any_op(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (!cv) count++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          bus_tick(1'b0, any_op(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          if (r < 25) begin
            op = any_op();
          end else if (!in_xfer) begin
            op         = OP_START;
            in_xfer    = 1'b1;
            bytes_left = $urandom_range(1, 4);
          end else if (bytes_left == 0) begin
            op = ($urandom_range(0, 3) == 0) ? OP_START : OP_STOP;
            if (op == OP_STOP) in_xfer = 1'b0;
            else bytes_left = $urandom_range(1, 4);
          end else begin
            op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE;
            bytes_left--;
          end
          // stretches are cheap only when the first low check times out
          if (op == OP_READ && poll_limit == 8'd1) scl_low_budget = $urandom_range(0, 8);
          bus_tick(1'b1, op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        count++;
      end
    end
  endtask

  task automatic test_random();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    set_config(1, 1, 0);
    random_traffic(125);
    set_config(2, 255, 5);
    random_traffic(125);
    repeat (2) begin
      set_config($urandom_range(1, 3), $urandom_range(1, 255), $urandom_range(0, 10));
      random_traffic(125);
    end
  endtask

  // Result receiver with random stalls and a long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    bus_result_t want;
    bus_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        note_mismatch("result with none pending", 0, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.scl !== want.scl) note_mismatch("scl_release", want.scl, got.scl);
        if (got.sda !== want.sda) note_mismatch("sda_release", want.sda, got.sda);
        if (got.busy !== want.busy) note_mismatch("busy_res", want.busy, got.busy);
        if (got.done !== want.done) note_mismatch("done_res", want.done, got.done);
        if (got.ack !== want.ack) note_mismatch("ack_ok", want.ack, got.ack);
        if (got.rx !== want.rx) note_mismatch("rx_byte", want.rx, got.rx);
        if (got.tmo !== want.tmo) note_mismatch("stretch_timeout", want.tmo, got.tmo);
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_START;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_ticks_zero();
    test_commands();
    test_clock_stretch();
    test_backpressure();
    test_random();
    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
